// ----- rtl/hfcm_pkg.sv -----
// Shared types and constants for the heatmap false-color mapper.
package hfcm_pkg;

	localparam int unsigned VAL_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned Q_W       = 16;
	localparam int unsigned T_W       = Q_W + 1;
	localparam int unsigned CH_W      = 8;
	localparam int unsigned LUM_W     = 18;

	localparam int unsigned DIV_STAGES = Q_W;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;

	localparam logic [VAL_W-1:0] RANGE_LOW_RST  = 16'd0;
	localparam logic [VAL_W-1:0] RANGE_HIGH_RST = 16'd1000;

	localparam logic [T_W-1:0] T_ONE  = 17'd65536;
	localparam logic [T_W-1:0] T_SEG1 = 17'd16384;
	localparam logic [T_W-1:0] T_SEG2 = 17'd32768;
	localparam logic [T_W-1:0] T_SEG3 = 17'd49152;

	localparam logic [LUM_W-1:0] LUM_R     = 18'd299;
	localparam logic [LUM_W-1:0] LUM_G     = 18'd587;
	localparam logic [LUM_W-1:0] LUM_B     = 18'd114;
	// floor(sum / 1000) > 150 holds exactly when sum >= 151000
	localparam logic [LUM_W-1:0] LUM_LIMIT = 18'd151000;

	localparam logic [CH_W-1:0] STOP_R [5] = '{8'd30, 8'd20, 8'd20, 8'd230, 8'd220};
	localparam logic [CH_W-1:0] STOP_G [5] = '{8'd60, 8'd170, 8'd170, 8'd200, 8'd40};
	localparam logic [CH_W-1:0] STOP_B [5] = '{8'd200, 8'd190, 8'd60, 8'd0, 8'd30};

	// One item travelling down the divider chain.
	typedef struct packed {
		logic [Q_W-1:0] rem;
		logic [Q_W-1:0] den;
		logic [Q_W-1:0] quot;
		logic           t_zero;
		logic           t_one;
	} div_t;

	// Interpolate one channel between stops a and b at fraction f (Q1.16).
	function automatic logic [CH_W-1:0] lerp_chan(
		input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b,
		input logic [T_W-1:0]  f
	);
		logic signed [CH_W:0]       d;
		logic signed [T_W+CH_W+1:0] prod;
		logic signed [T_W+CH_W+1:0] acc;
		d    = $signed({1'b0, b}) - $signed({1'b0, a});
		prod = $signed({1'b0, f}) * d;
		acc  = $signed({3'b000, a, 16'h0000}) + prod;
		return acc[16 +: CH_W];
	endfunction

endpackage

// ----- rtl/hfcm_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per item.
module hfcm_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hfcm_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output hfcm_pkg::div_t out_data
);
	import hfcm_pkg::*;

	logic           v_q;
	div_t           d_q;
	logic [Q_W:0]   rem2;
	logic           take;
	div_t           nxt;

	always_comb begin
		rem2 = {in_data.rem, 1'b0};
		take = rem2 >= {1'b0, in_data.den};
		nxt  = in_data;
		if (take) begin
			nxt.rem = Q_W'(rem2 - {1'b0, in_data.den});
		end else begin
			nxt.rem = rem2[Q_W-1:0];
		end
		nxt.quot = {in_data.quot[Q_W-2:0], take};
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data  = d_q;
endmodule

// ----- rtl/hfcm_lerp.sv -----
// Segment select and per-channel linear interpolation stage.
module hfcm_lerp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  hfcm_pkg::div_t            in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [hfcm_pkg::CH_W-1:0] red,
	output logic [hfcm_pkg::CH_W-1:0] green,
	output logic [hfcm_pkg::CH_W-1:0] blue
);
	import hfcm_pkg::*;

	logic            v_q;
	logic [CH_W-1:0] r_q, g_q, b_q;
	logic [T_W-1:0]  t;
	logic [1:0]      seg;
	logic [2:0]      lo_i, hi_i;
	logic [T_W-1:0]  diff;
	logic [T_W-1:0]  f;

	always_comb begin
		if (in_data.t_one) begin
			t = T_ONE;
		end else if (in_data.t_zero) begin
			t = '0;
		end else begin
			t = {1'b0, in_data.quot};
		end
		// a t exactly on a stop stays in the lower segment
		if (t <= T_SEG1) begin
			seg = 2'd0;
		end else if (t <= T_SEG2) begin
			seg = 2'd1;
		end else if (t <= T_SEG3) begin
			seg = 2'd2;
		end else begin
			seg = 2'd3;
		end
		lo_i = {1'b0, seg};
		hi_i = lo_i + 3'd1;
		diff = t - {1'b0, seg, 14'h0000};
		f    = {diff[14:0], 2'b00};
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			r_q <= lerp_chan(STOP_R[lo_i], STOP_R[hi_i], f);
			g_q <= lerp_chan(STOP_G[lo_i], STOP_G[hi_i], f);
			b_q <= lerp_chan(STOP_B[lo_i], STOP_B[hi_i], f);
		end
	end

	assign out_valid = v_q;
	assign red       = r_q;
	assign green     = g_q;
	assign blue      = b_q;
endmodule

// ----- rtl/heatmap_false_color_mapper_core.sv -----
// Top level of the heatmap false-color mapper.
// Maps a signed 16-bit cell_value onto a five-stop blue-cyan-green-yellow-red
// gradient over the window [range_low, range_high] and returns 8-bit red,
// green and blue plus black_text (luminance above 150). The block takes one
// transaction per clock while the output is not stalled. An item passes the
// front register (clamp and subtract), a chain of restoring-division cells
// (one quotient bit per cell, which sets the depth), the interpolation
// stage and the output register with the luminance test. Every stage has
// its own valid bit and a ready that looks
// only at its neighbor, so bubbles collapse and new input keeps flowing while
// a finished result waits. Write range_low (index 0) and range_high (index 1)
// only while no transaction is in flight; other indexes are ignored. An empty
// or inverted range maps every value to the blue stop.
module heatmap_false_color_mapper_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [hfcm_pkg::VAL_W-1:0] cell_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [hfcm_pkg::CH_W-1:0]      red,
	output logic [hfcm_pkg::CH_W-1:0]      green,
	output logic [hfcm_pkg::CH_W-1:0]      blue,
	output logic                           black_text,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hfcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hfcm_pkg::VAL_W-1:0]     cfg_data
);
	import hfcm_pkg::*;

	// Configuration registers
	logic signed [VAL_W-1:0] range_low_q;
	logic signed [VAL_W-1:0] range_high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RANGE_LOW:  range_low_q  <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front stage: clamp against the window and set up the division
	logic              inv_range;
	logic              at_low;
	logic              at_high;
	logic signed [VAL_W:0] num_w;
	logic signed [VAL_W:0] den_w;
	div_t              front;
	logic              v_s1;
	div_t              d_s1;

	always_comb begin
		inv_range = range_high_q <= range_low_q;
		at_low    = cell_value <= range_low_q;
		at_high   = cell_value >= range_high_q;
		num_w     = $signed({cell_value[VAL_W-1], cell_value})
		          - $signed({range_low_q[VAL_W-1], range_low_q});
		den_w     = $signed({range_high_q[VAL_W-1], range_high_q})
		          - $signed({range_low_q[VAL_W-1], range_low_q});
		front.t_zero = inv_range || at_low;
		front.t_one  = !inv_range && !at_low && at_high;
		front.quot   = '0;
		front.den    = den_w[Q_W-1:0];
		// zero the remainder on saturated items; the quotient is overridden anyway
		front.rem    = (front.t_zero || front.t_one) ? '0 : num_w[Q_W-1:0];
	end

	logic chain_ready [DIV_STAGES+1];
	logic chain_valid [DIV_STAGES+1];
	div_t chain_data  [DIV_STAGES+1];

	assign in_ready = !v_s1 || chain_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_s1 <= front;
		end
	end

	assign chain_valid[0] = v_s1;
	assign chain_data[0]  = d_s1;

	// Divider chain: each cell resolves one quotient bit, MSB first
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		hfcm_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	// Interpolation stage
	logic            lerp_valid;
	logic            lerp_ready;
	logic [CH_W-1:0] lerp_r, lerp_g, lerp_b;

	hfcm_lerp u_lerp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[DIV_STAGES]),
		.in_ready  (chain_ready[DIV_STAGES]),
		.in_data   (chain_data[DIV_STAGES]),
		.out_valid (lerp_valid),
		.out_ready (lerp_ready),
		.red       (lerp_r),
		.green     (lerp_g),
		.blue      (lerp_b)
	);

	// Output register with the luminance test
	logic [LUM_W-1:0] lum_sum;
	logic             out_v_q;
	logic [CH_W-1:0]  red_q, green_q, blue_q;
	logic             dark_q;

	assign lum_sum = LUM_R * LUM_W'(lerp_r) + LUM_G * LUM_W'(lerp_g)
	               + LUM_B * LUM_W'(lerp_b);

	assign lerp_ready = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (lerp_ready) begin
			out_v_q <= lerp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (lerp_valid && lerp_ready) begin
			red_q   <= lerp_r;
			green_q <= lerp_g;
			blue_q  <= lerp_b;
			dark_q  <= lum_sum >= LUM_LIMIT;
		end
	end

	assign out_valid  = out_v_q;
	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;
	assign black_text = dark_q;

	// A saturated item is either at the bottom or at the top, never both
	a_sat_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !(d_s1.t_zero && d_s1.t_one))
		else $error("front stage marks an item both zero and one");

	// An inverted or empty window always yields the blue stop
	a_inv_blue: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (range_high_q <= range_low_q))
		|-> (red == 8'd30 && green == 8'd60 && blue == 8'd200 && !black_text))
		else $error("inverted range did not give the blue stop");

	// Input backpressure only comes from a full pipe held at the output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without an output stall");

	// An output that is not taken is held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(red) && $stable(black_text)))
		else $error("output transaction dropped while stalled");
endmodule
